// File: sv/watermark_rate_controller_macros.svh
// Assertion wrappers for the watermark rate controller.
// Define NO_ASSERTIONS to compile them out.
`ifndef WATERMARK_RATE_CONTROLLER_MACROS_SVH
`define WATERMARK_RATE_CONTROLLER_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked only while out of reset
`define WRC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("wrc assertion failed");

// checked on every edge, reset included
`define WRC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("wrc assertion failed");

`else

`define WRC_ASSERT(label, clk, rst_n, prop)
`define WRC_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// File: sv/wrc_pkg.sv
`timescale 1ns / 1ps

package wrc_pkg;

    localparam int FILL_WIDTH   = 24;
    localparam int FRAC_BITS    = 14;
    localparam int FACTOR_WIDTH = 16;
    localparam int FACT_W       = FRAC_BITS + 2;
    localparam int CNT_W        = $clog2(FRAC_BITS + 1);
    localparam int ADDR_W       = 4;
    localparam int DATA_W       = 32;

    localparam logic [FILL_WIDTH-1:0] LOW_MARK_RST   = FILL_WIDTH'(9000);
    localparam logic [FILL_WIDTH-1:0] HIGH_MARK_RST  = FILL_WIDTH'(45000);
    localparam logic [FILL_WIDTH-1:0] HYSTERESIS_RST = FILL_WIDTH'(4500);

    localparam logic [FACT_W-1:0] FX_ONE  = FACT_W'(1) << FRAC_BITS;
    localparam logic [FACT_W-1:0] FX_TWO  = FACT_W'(2) << FRAC_BITS;
    localparam logic [FACT_W-1:0] FX_HALF = FACT_W'(1) << (FRAC_BITS - 1);
    localparam logic [FACT_W-1:0] FX_ZERO = '0;

    // fill_state codes
    localparam logic [1:0] ST_NORMAL = 2'd0;
    localparam logic [1:0] ST_HIGH   = 2'd1;
    localparam logic [1:0] ST_LOW    = 2'd2;

    // register indexes
    localparam logic [1:0] REG_LOW_MARK   = 2'd0;
    localparam logic [1:0] REG_HIGH_MARK  = 2'd1;
    localparam logic [1:0] REG_HYSTERESIS = 2'd2;

    typedef struct packed {
        logic [FILL_WIDTH-1:0] low_mark;
        logic [FILL_WIDTH-1:0] high_mark;
        logic [FILL_WIDTH-1:0] hysteresis;
    } cfg_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: sv/wrc_regs.sv
`timescale 1ns / 1ps

module wrc_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [wrc_pkg::ADDR_W-1:0] paddr,
    input  logic [wrc_pkg::DATA_W-1:0] pwdata,
    output logic [wrc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output wrc_pkg::cfg_t              cfg
);
    import wrc_pkg::*;

    logic [FILL_WIDTH-1:0] low_mark_reg;
    logic [FILL_WIDTH-1:0] high_mark_reg;
    logic [FILL_WIDTH-1:0] hysteresis_reg;
    logic [1:0]            reg_index;
    logic                  wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_mark_reg   <= LOW_MARK_RST;
            high_mark_reg  <= HIGH_MARK_RST;
            hysteresis_reg <= HYSTERESIS_RST;
        end else if (wr_en) begin
            unique case (reg_index)
                REG_LOW_MARK:   low_mark_reg   <= pwdata[FILL_WIDTH-1:0];
                REG_HIGH_MARK:  high_mark_reg  <= pwdata[FILL_WIDTH-1:0];
                REG_HYSTERESIS: hysteresis_reg <= pwdata[FILL_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_LOW_MARK:   prdata = DATA_W'(low_mark_reg);
            REG_HIGH_MARK:  prdata = DATA_W'(high_mark_reg);
            REG_HYSTERESIS: prdata = DATA_W'(hysteresis_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.low_mark   = low_mark_reg;
    assign cfg.high_mark  = high_mark_reg;
    assign cfg.hysteresis = hysteresis_reg;

endmodule

// File: sv/wrc_div.sv
`timescale 1ns / 1ps

// Restoring fraction divider: one shift/compare/subtract per cycle,
// for each of the FRAC_BITS quotient bits. Needs dividend < divisor.
module wrc_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  wrc_pkg::div_ctrl_t             ctrl,
    input  logic [wrc_pkg::FILL_WIDTH-1:0] dividend,
    input  logic [wrc_pkg::FILL_WIDTH-1:0] divisor,
    output wrc_pkg::div_stat_t             stat,
    output logic [wrc_pkg::FRAC_BITS-1:0]  quotient
);
    import wrc_pkg::*;

    logic [FILL_WIDTH:0]   rem_reg;
    logic [FILL_WIDTH-1:0] div_reg;
    logic [FRAC_BITS-1:0]  q_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [FILL_WIDTH:0]   shifted;
    logic                  fits;

    // rem < divisor, so the top bit is clear before the shift
    assign shifted = {rem_reg[FILL_WIDTH-1:0], 1'b0};
    assign fits    = shifted >= {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(FRAC_BITS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            rem_reg <= {1'b0, dividend};
            div_reg <= divisor;
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? shifted - {1'b0, div_reg} : shifted;
            q_reg   <= {q_reg[FRAC_BITS-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;

endmodule

// File: sv/watermark_rate_controller.sv
`timescale 1ns / 1ps

// Watermark flow control with hysteresis. Each fill sample (90 kHz ticks)
// updates the high/low flags and yields one word: a Q2.14 speed factor and
// the fill state. A sample goes from S_EVAL straight to S_DONE when the
// factor is fixed (normal state, zero midpoint, or a distance from the
// mark of at least the midpoint) and passes through S_DIV when it needs a
// quotient: the restoring divider yields one of the 14 fraction
// bits per cycle. s_ready is high only while no sample is in work; a
// finished word sits in the output register, so the next sample may be
// taken before it is read. Registers (APB, byte address 4*i): low_mark,
// high_mark, hysteresis; keep low_mark below high_mark.
module watermark_rate_controller (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wrc_pkg::ADDR_W-1:0]        paddr,
    input  logic [wrc_pkg::DATA_W-1:0]        pwdata,
    output logic [wrc_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [wrc_pkg::FILL_WIDTH-1:0]    s_fill_level,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [wrc_pkg::FACTOR_WIDTH-1:0]  m_rate_factor,
    output logic [1:0]                        m_fill_state
);
    import wrc_pkg::*;

    `include "watermark_rate_controller_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    cfg_t                    cfg;
    div_ctrl_t               div_ctrl;
    div_stat_t               div_stat;
    logic [FRAC_BITS-1:0]    quotient;

    logic [FILL_WIDTH-1:0]   fill_reg;
    logic                    high_flag_reg, low_flag_reg;
    logic                    up_reg, sat_reg, mid0_reg;
    logic                    m_valid_reg;
    logic [FACTOR_WIDTH-1:0] speed_reg;
    logic [1:0]              fstate_reg;

    logic                    high_keep, low_keep, high_next, low_next;
    logic [FILL_WIDTH:0]     mid_sum;
    logic [FILL_WIDTH-1:0]   mid, ref_mark, mag;
    logic                    up, sat, mid0;
    logic [FACT_W-1:0]       q_ext, factor;
    logic                    load_out;

    wrc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // flag update, widened so nothing wraps
    always_comb begin
        high_keep = high_flag_reg &&
            !(({1'b0, fill_reg} + {1'b0, cfg.hysteresis}) < {1'b0, cfg.high_mark});
        low_keep  = low_flag_reg &&
            !({1'b0, fill_reg} > ({1'b0, cfg.low_mark} + {1'b0, cfg.hysteresis}));
        if (!high_keep && !low_keep) begin
            high_next = fill_reg > cfg.high_mark;
            low_next  = !high_next && (fill_reg < cfg.low_mark);
        end else begin
            high_next = high_keep;
            low_next  = low_keep;
        end
    end

    // distance from the governing watermark and its direction
    always_comb begin
        mid_sum  = {1'b0, cfg.low_mark} + {1'b0, cfg.high_mark};
        mid      = mid_sum[FILL_WIDTH:1];
        mid0     = mid == '0;
        ref_mark = high_next ? cfg.high_mark : cfg.low_mark;
        up       = high_next ? (fill_reg >= cfg.high_mark) : (fill_reg > cfg.low_mark);
        mag      = up ? fill_reg - ref_mark : ref_mark - fill_reg;
        sat      = mid0 || (mag >= mid);
    end

    assign div_ctrl.start = (state_reg == S_EVAL) && (high_next || low_next) && !sat;

    wrc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .dividend (mag),
        .divisor  (mid),
        .stat     (div_stat),
        .quotient (quotient)
    );

    always_comb begin
        q_ext = FACT_W'(quotient);
        if (high_flag_reg) begin
            if (sat_reg)     factor = (mid0_reg || up_reg) ? FX_TWO : FX_ZERO;
            else if (up_reg) factor = FX_ONE + q_ext;
            else             factor = FX_ONE - q_ext;
        end else if (low_flag_reg) begin
            if (mid0_reg)     factor = FX_HALF;
            else if (sat_reg) factor = up_reg ? FX_TWO : FX_HALF;
            else if (up_reg)  factor = FX_ONE + q_ext;
            else if ((FX_ONE - q_ext) < FX_HALF) factor = FX_HALF;
            else              factor = FX_ONE - q_ext;
        end else begin
            factor = FX_ONE;
        end
    end

    assign load_out = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_valid) state_next = S_EVAL;
            S_EVAL: state_next = div_ctrl.start ? S_DIV : S_DONE;
            S_DIV:  if (div_stat.done) state_next = S_DONE;
            S_DONE: if (load_out) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            high_flag_reg <= 1'b0;
            low_flag_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_EVAL) begin
                high_flag_reg <= high_next;
                low_flag_reg  <= low_next;
            end
            if (load_out)     m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) fill_reg <= s_fill_level;
        if (state_reg == S_EVAL) begin
            up_reg   <= up;
            sat_reg  <= sat;
            mid0_reg <= mid0;
        end
        if (load_out) begin
            speed_reg  <= FACTOR_WIDTH'(factor);
            fstate_reg <= high_flag_reg ? ST_HIGH : (low_flag_reg ? ST_LOW : ST_NORMAL);
        end
    end

    assign s_ready       = state_reg == S_IDLE;
    assign m_valid       = m_valid_reg;
    assign m_rate_factor = speed_reg;
    assign m_fill_state  = fstate_reg;

    `WRC_ASSERT(a_accept_to_eval, aclk, aresetn, s_valid && s_ready |=> state_reg == S_EVAL)
    `WRC_ASSERT(a_div_done_in_div, aclk, aresetn, div_stat.done |-> state_reg == S_DIV)
    `WRC_ASSERT(a_normal_unity, aclk, aresetn, m_valid && m_fill_state == ST_NORMAL |-> m_rate_factor == FACTOR_WIDTH'(FX_ONE))
    `WRC_ASSERT(a_flags_exclusive, aclk, aresetn, !(high_flag_reg && low_flag_reg))
    `WRC_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> state_reg == S_IDLE && !m_valid)

endmodule
